/* sv/blte_pkg.sv */
// package for the bounded list table engine: sizes, command and status codes
package blte_pkg;
    localparam int unsigned LIST_CAPACITY = 64;
    localparam int unsigned ADDR_W = $clog2(LIST_CAPACITY);
    localparam int unsigned CNT_W = $clog2(LIST_CAPACITY + 1);
    localparam int unsigned DATA_W = 32;

    localparam logic [3:0] CMD_INS_FIRST = 4'd0;
    localparam logic [3:0] CMD_INS_AT = 4'd1;
    localparam logic [3:0] CMD_INS_LAST = 4'd2;
    localparam logic [3:0] CMD_DEL_FIRST = 4'd3;
    localparam logic [3:0] CMD_DEL_AT = 4'd4;
    localparam logic [3:0] CMD_DEL_LAST = 4'd5;
    localparam logic [3:0] CMD_FIND = 4'd6;
    localparam logic [3:0] CMD_EXTREMES = 4'd7;
    localparam logic [3:0] CMD_SORT_UP = 4'd8;
    localparam logic [3:0] CMD_SORT_DOWN = 4'd9;
    localparam logic [3:0] CMD_CLEAR = 4'd10;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BADIDX = 2'd3;

    typedef struct packed {
        logic we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_ctl_t;
endpackage

/* sv/blte_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module blte_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/blte_seq.sv */
// sequencer: walks the list through the ram one entry per step
module blte_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [3:0]                    cmd,
    input  logic [5:0]                    position,
    input  logic signed [31:0]            operand_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            removed_value,
    output logic [5:0]                    found_index,
    output logic                          found,
    output logic signed [31:0]            largest,
    output logic signed [31:0]            smallest,
    output logic [6:0]                    count_now,
    output logic [1:0]                    status,
    output blte_pkg::ram_ctl_t            ram_ctl,
    input  logic [blte_pkg::DATA_W-1:0]   ram_rdata
);
    import blte_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD = 3'd1;
    localparam logic [2:0] S_USE = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    localparam logic [2:0] OP_INS = 3'd0;
    localparam logic [2:0] OP_DEL = 3'd1;
    localparam logic [2:0] OP_FIND = 3'd2;
    localparam logic [2:0] OP_EXT = 3'd3;
    localparam logic [2:0] OP_SORT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic up_reg, up_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [31:0] rem_reg, rem_next;
    logic signed [31:0] hi_reg, hi_next;
    logic signed [31:0] lo_reg, lo_next;
    logic [5:0] fidx_reg, fidx_next;
    logic fnd_reg, fnd_next;
    logic [1:0] st_reg, st_next;
    logic signed [31:0] rd;
    logic [CNT_W-1:0] posx;

    assign rd = $signed(ram_rdata);
    assign posx = CNT_W'(position);
    assign in_ready = (state_reg == S_IDLE) && !out_valid;
    assign removed_value = rem_reg;
    assign found_index = fidx_reg;
    assign found = fnd_reg;
    assign largest = hi_reg;
    assign smallest = lo_reg;
    assign count_now = 7'(count_reg);
    assign status = st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            else if (state_reg == S_DONE)
            begin
                out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        i_reg <= i_next;
        j_reg <= j_next;
        pos_reg <= pos_next;
        up_reg <= up_next;
        val_reg <= val_next;
        rem_reg <= rem_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        fidx_reg <= fidx_next;
        fnd_reg <= fnd_next;
        st_reg <= st_next;
    end

    // sort: i is the element being placed, val holds it, j walks down
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        count_next = count_reg;
        i_next = i_reg;
        j_next = j_reg;
        pos_next = pos_reg;
        up_next = up_reg;
        val_next = val_reg;
        rem_next = rem_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        fidx_next = fidx_reg;
        fnd_next = fnd_reg;
        st_next = st_reg;
        ram_ctl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    rem_next = '0;
                    hi_next = '0;
                    lo_next = '0;
                    fidx_next = '0;
                    fnd_next = 1'b0;
                    st_next = ST_OK;
                    val_next = operand_value;
                    state_next = S_DONE;
                    case (cmd)
                        CMD_INS_FIRST, CMD_INS_AT, CMD_INS_LAST:
                        begin
                            if (count_reg >= CNT_W'(LIST_CAPACITY))
                            begin
                                st_next = ST_FULL;
                            end
                            else if (cmd == CMD_INS_AT && posx > count_reg)
                            begin
                                st_next = ST_BADIDX;
                            end
                            else
                            begin
                                op_next = OP_INS;
                                pos_next = (cmd == CMD_INS_FIRST) ? '0 :
                                           (cmd == CMD_INS_LAST) ? count_reg : posx;
                                i_next = count_reg;
                                state_next = S_RD;
                            end
                        end
                        CMD_DEL_FIRST, CMD_DEL_AT, CMD_DEL_LAST:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else if (cmd == CMD_DEL_AT && posx >= count_reg)
                            begin
                                st_next = ST_BADIDX;
                            end
                            else
                            begin
                                op_next = OP_DEL;
                                i_next = (cmd == CMD_DEL_FIRST) ? '0 :
                                         (cmd == CMD_DEL_LAST) ? count_reg - 1'b1 : posx;
                                j_next = '0;
                                state_next = S_RD;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (count_reg != '0)
                            begin
                                op_next = OP_FIND;
                                i_next = '0;
                                state_next = S_RD;
                            end
                        end
                        CMD_EXTREMES:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                op_next = OP_EXT;
                                i_next = '0;
                                state_next = S_RD;
                            end
                        end
                        CMD_SORT_UP, CMD_SORT_DOWN:
                        begin
                            if (count_reg > CNT_W'(1))
                            begin
                                op_next = OP_SORT;
                                up_next = (cmd == CMD_SORT_UP);
                                i_next = CNT_W'(1);
                                j_next = '0;
                                pos_next = '0;
                                state_next = S_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                case (op_reg)
                    OP_INS:
                    begin
                        if (i_reg == pos_reg)
                        begin
                            ram_ctl.we = 1'b1;
                            ram_ctl.waddr = ADDR_W'(pos_reg);
                            ram_ctl.wdata = val_reg;
                            count_next = count_reg + 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ram_ctl.raddr = ADDR_W'(i_reg - 1'b1);
                            state_next = S_USE;
                        end
                    end
                    OP_DEL:
                    begin
                        // j flags the first read, which fetches the removed value
                        if (j_reg == '0)
                        begin
                            ram_ctl.raddr = ADDR_W'(i_reg);
                            state_next = S_USE;
                        end
                        else if (i_reg + 1'b1 >= count_reg)
                        begin
                            count_next = count_reg - 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ram_ctl.raddr = ADDR_W'(i_reg + 1'b1);
                            state_next = S_USE;
                        end
                    end
                    OP_SORT:
                    begin
                        // pos flags: 0 load element i, 1 read j-1 for compare
                        if (pos_reg == '0)
                        begin
                            ram_ctl.raddr = ADDR_W'(i_reg);
                        end
                        else
                        begin
                            ram_ctl.raddr = ADDR_W'(j_reg - 1'b1);
                        end
                        state_next = S_USE;
                    end
                    default:
                    begin
                        ram_ctl.raddr = ADDR_W'(i_reg);
                        state_next = S_USE;
                    end
                endcase
            end
            S_USE:
            begin
                state_next = S_RD;
                case (op_reg)
                    OP_INS:
                    begin
                        ram_ctl.we = 1'b1;
                        ram_ctl.waddr = ADDR_W'(i_reg);
                        ram_ctl.wdata = ram_rdata;
                        i_next = i_reg - 1'b1;
                    end
                    OP_DEL:
                    begin
                        if (j_reg == '0)
                        begin
                            rem_next = rd;
                            j_next = CNT_W'(1);
                        end
                        else
                        begin
                            ram_ctl.we = 1'b1;
                            ram_ctl.waddr = ADDR_W'(i_reg);
                            ram_ctl.wdata = ram_rdata;
                            i_next = i_reg + 1'b1;
                        end
                    end
                    OP_FIND:
                    begin
                        if (rd == val_reg)
                        begin
                            fnd_next = 1'b1;
                            fidx_next = 6'(i_reg);
                            state_next = S_DONE;
                        end
                        else if (i_reg + 1'b1 >= count_reg)
                        begin
                            state_next = S_DONE;
                        end
                        i_next = i_reg + 1'b1;
                    end
                    OP_EXT:
                    begin
                        if (i_reg == '0 || rd > hi_reg)
                        begin
                            hi_next = rd;
                        end
                        if (i_reg == '0 || rd < lo_reg)
                        begin
                            lo_next = rd;
                        end
                        if (i_reg + 1'b1 >= count_reg)
                        begin
                            state_next = S_DONE;
                        end
                        i_next = i_reg + 1'b1;
                    end
                    OP_SORT:
                    begin
                        if (pos_reg == '0)
                        begin
                            val_next = rd;
                            j_next = i_reg;
                            pos_next = CNT_W'(1);
                        end
                        else if (up_reg ? (val_reg < rd) : (val_reg > rd))
                        begin
                            ram_ctl.we = 1'b1;
                            ram_ctl.waddr = ADDR_W'(j_reg);
                            ram_ctl.wdata = ram_rdata;
                            j_next = j_reg - 1'b1;
                            if (j_reg == CNT_W'(1))
                            begin
                                // cannot write twice in one cycle: finish placement next
                                pos_next = CNT_W'(2);
                                state_next = S_USE;
                            end
                        end
                        else
                        begin
                            pos_next = CNT_W'(2);
                            state_next = S_USE;
                        end
                        if (pos_reg == CNT_W'(2))
                        begin
                            ram_ctl.we = 1'b1;
                            ram_ctl.waddr = ADDR_W'(j_reg);
                            ram_ctl.wdata = val_reg;
                            i_next = i_reg + 1'b1;
                            j_next = j_reg;
                            pos_next = '0;
                            val_next = val_reg;
                            state_next = (i_reg + 1'b1 >= count_reg) ? S_DONE : S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

/* sv/bounded_list_table_engine_top.sv */
// top level of the bounded list table engine
// refused, clear and empty-list commands go straight to the response; others walk the entries they move or scan
// insert and delete: a ram read and a ram write per shifted entry; find and extremes: a ram read per entry scanned
// sort: insertion sort, a ram read per compare, shifting out-of-order entries up one place to make room
// one transaction at a time; every entry goes through the single ram read port
// reset clears the count and the handshake; list contents stay undefined until written
module bounded_list_table_engine_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         cmd,
    input  logic [5:0]         position,
    input  logic signed [31:0] operand_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] removed_value,
    output logic [5:0]         found_index,
    output logic               found,
    output logic signed [31:0] largest,
    output logic signed [31:0] smallest,
    output logic [6:0]         count_now,
    output logic [1:0]         status
);
    import blte_pkg::*;

    ram_ctl_t ram_ctl;
    logic [DATA_W-1:0] ram_rdata;

    blte_seq u_seq (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .position(position), .operand_value(operand_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .removed_value(removed_value), .found_index(found_index), .found(found),
        .largest(largest), .smallest(smallest), .count_now(count_now),
        .status(status), .ram_ctl(ram_ctl), .ram_rdata(ram_rdata)
    );

    blte_ram #(.WIDTH(DATA_W), .DEPTH(LIST_CAPACITY)) u_ram (
        .clk(clk), .we(ram_ctl.we), .waddr(ram_ctl.waddr), .wdata(ram_ctl.wdata),
        .raddr(ram_ctl.raddr), .rdata(ram_rdata)
    );
endmodule

/* tb/tb_bounded_list_table_engine_top.sv */
// self-checking testbench for the bounded list table engine: queued commands, list predictor
`timescale 1ns / 1ps
module tb_bounded_list_table_engine_top;
    import blte_pkg::*;

    typedef struct packed {
        logic [3:0]         op;
        logic [5:0]         pos;
        logic signed [31:0] val;
    } list_cmd_t;

    typedef struct packed {
        logic signed [31:0] removed;
        logic [5:0]         fidx;
        logic               fnd;
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic [6:0]         cnt;
        logic [1:0]         st;
    } list_resp_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [3:0]         cmd;
    logic [5:0]         position;
    logic signed [31:0] operand_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] removed_value;
    logic [5:0]         found_index;
    logic               found;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
    logic [6:0]         count_now;
    logic [1:0]         status;

    list_cmd_t  pending_cmds[$];
    list_resp_t expected_resps[$];
    logic signed [31:0] shadow_list[LIST_CAPACITY];
    int unsigned shadow_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatch_count;
    int unsigned resp_count;
    int unsigned cmd_count;
    int unsigned op_hits[16];
    bit          stim_done;
    bit          in_taken;

    bounded_list_table_engine_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .position(position), .operand_value(operand_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .removed_value(removed_value), .found_index(found_index), .found(found),
        .largest(largest), .smallest(smallest),
        .count_now(count_now), .status(status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic list_resp_t apply_list_cmd(list_cmd_t c);
        list_resp_t r;
        logic signed [31:0] t;
        int unsigned at;
        int j;
        r = '0;
        r.st = ST_OK;
        case (c.op)
            CMD_INS_FIRST, CMD_INS_AT, CMD_INS_LAST:
            begin
                at = (c.op == CMD_INS_FIRST) ? 0 :
                     (c.op == CMD_INS_LAST) ? shadow_count : c.pos;
                if (shadow_count >= LIST_CAPACITY)
                    r.st = ST_FULL;
                else if (at > shadow_count)
                    r.st = ST_BADIDX;
                else
                begin
                    for (j = shadow_count; j > at; j--)
                        shadow_list[j] = shadow_list[j-1];
                    shadow_list[at] = c.val;
                    shadow_count++;
                end
            end
            CMD_DEL_FIRST, CMD_DEL_AT, CMD_DEL_LAST:
            begin
                at = (c.op == CMD_DEL_FIRST) ? 0 :
                     (c.op == CMD_DEL_LAST) ? shadow_count - 1 : c.pos;
                if (shadow_count == 0)
                    r.st = ST_EMPTY;
                else if (at >= shadow_count)
                    r.st = ST_BADIDX;
                else
                begin
                    r.removed = shadow_list[at];
                    for (j = at; j + 1 < shadow_count; j++)
                        shadow_list[j] = shadow_list[j+1];
                    shadow_count--;
                end
            end
            CMD_FIND:
            begin
                for (j = shadow_count - 1; j >= 0; j--)
                    if (shadow_list[j] == c.val)
                    begin
                        r.fidx = 6'(j);
                        r.fnd = 1'b1;
                    end
            end
            CMD_EXTREMES:
            begin
                if (shadow_count == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    r.hi = shadow_list[0];
                    r.lo = shadow_list[0];
                    for (j = 1; j < shadow_count; j++)
                    begin
                        if (shadow_list[j] > r.hi) r.hi = shadow_list[j];
                        if (shadow_list[j] < r.lo) r.lo = shadow_list[j];
                    end
                end
            end
            CMD_SORT_UP, CMD_SORT_DOWN:
            begin
                for (int i = 1; i < shadow_count; i++)
                begin
                    t = shadow_list[i];
                    j = i;
                    while (j > 0 && ((c.op == CMD_SORT_UP) ? (t < shadow_list[j-1])
                                                           : (t > shadow_list[j-1])))
                    begin
                        shadow_list[j] = shadow_list[j-1];
                        j--;
                    end
                    shadow_list[j] = t;
                end
            end
            CMD_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        r.cnt = shadow_count[6:0];
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 7) - 3;
            3: return (shadow_count > 0) ? shadow_list[$urandom_range(0, shadow_count - 1)]
                                         : $urandom();
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_cmd(input logic [3:0] op, input logic [5:0] pos,
                             input logic signed [31:0] val);
        list_cmd_t c;
        c.op = op;
        c.pos = pos;
        c.val = val;
        pending_cmds.push_back(c);
        expected_resps.push_back(apply_list_cmd(c));
        op_hits[op]++;
        cmd_count++;
    endtask

    task automatic queue_random_cmd();
        logic [3:0] op;
        int unsigned roll;
        logic [5:0] pos;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            op = (shadow_count > 56) ? CMD_DEL_AT : 4'($urandom_range(0, 2));
        else if (roll < 70)
            op = CMD_DEL_FIRST + 4'($urandom_range(0, 2));
        else if (roll < 80)
            op = CMD_FIND;
        else if (roll < 86)
            op = CMD_EXTREMES;
        else if (roll < 93)
            op = CMD_SORT_UP + 4'($urandom_range(0, 1));
        else if (roll < 96)
            op = CMD_CLEAR;
        else
            op = 4'($urandom_range(11, 15));
        if ($urandom_range(0, 9) == 0)
            pos = 6'($urandom());
        else
            pos = 6'($urandom_range(0, shadow_count));
        queue_cmd(op, pos, pick_value());
    endtask

    task automatic drain_and_set(input int unsigned idle_pct, input int unsigned stall_pct);
        while (pending_cmds.size() != 0 || expected_resps.size() != 0)
            @(posedge clk);
        @(negedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                cmd <= pending_cmds[0].op;
                position <= pending_cmds[0].pos;
                operand_value <= pending_cmds[0].val;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            void'(pending_cmds.pop_front());
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        list_resp_t got;
        list_resp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {removed_value, found_index, found, largest, smallest, count_now, status};
            resp_count++;
            if (expected_resps.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: %p", got);
            end
            else
            begin
                want = expected_resps.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch on response %0d: expected %p, got %p",
                                 resp_count, want, got);
                end
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cmd = '0;
        position = '0;
        operand_value = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        resp_count = 0;
        cmd_count = 0;
        shadow_count = 0;
        stim_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty list, bad indexes, extremes of values
        queue_cmd(CMD_DEL_FIRST, 0, 0);
        queue_cmd(CMD_DEL_AT, 0, 0);
        queue_cmd(CMD_DEL_LAST, 0, 0);
        queue_cmd(CMD_EXTREMES, 0, 0);
        queue_cmd(CMD_FIND, 0, 0);
        queue_cmd(CMD_SORT_UP, 0, 0);
        queue_cmd(CMD_INS_AT, 1, 5);
        queue_cmd(CMD_INS_AT, 0, 32'sh7fffffff);
        queue_cmd(CMD_DEL_LAST, 0, 0);
        queue_cmd(CMD_INS_LAST, 0, 32'sh80000000);
        queue_cmd(CMD_INS_FIRST, 0, 32'sh7fffffff);
        queue_cmd(CMD_INS_AT, 2, -1);
        queue_cmd(CMD_INS_AT, 1, 0);
        queue_cmd(CMD_EXTREMES, 0, 0);
        queue_cmd(CMD_FIND, 0, -1);
        queue_cmd(CMD_FIND, 0, 12345);
        queue_cmd(CMD_DEL_AT, 4, 0);
        queue_cmd(CMD_SORT_UP, 0, 0);
        queue_cmd(CMD_SORT_DOWN, 0, 0);
        queue_cmd(CMD_DEL_AT, 1, 0);
        queue_cmd(4'd11, 6'h3f, -1);
        queue_cmd(4'd15, 0, 0);
        queue_cmd(CMD_CLEAR, 0, 0);
        // fill to capacity, overflow, then position 63
        for (int i = 0; i < LIST_CAPACITY; i++)
            queue_cmd(CMD_INS_LAST, 0, $urandom());
        queue_cmd(CMD_INS_FIRST, 0, 1);
        queue_cmd(CMD_INS_AT, 6'h3f, 1);
        queue_cmd(CMD_SORT_DOWN, 0, 0);
        queue_cmd(CMD_DEL_AT, 6'h3f, 0);
        queue_cmd(CMD_CLEAR, 0, 0);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: drain_and_set(0, 0);
                1: drain_and_set(63, 0);
                2: drain_and_set(0, 63);
                default: drain_and_set(13, 13);
            endcase
            for (int k = 0; k < 150; k++)
                queue_random_cmd();
        end
        drain_and_set(0, 0);
        repeat (20) @(posedge clk);

        $display("ran %0d commands through four handshake mixes, %0d responses checked",
                 cmd_count, resp_count);
        $display("inserts %0d, deletes %0d, sorts %0d, full-list fills reached capacity",
                 op_hits[0] + op_hits[1] + op_hits[2], op_hits[3] + op_hits[4] + op_hits[5],
                 op_hits[8] + op_hits[9]);
        if (mismatch_count == 0 && expected_resps.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
